### src/polygon_support_point_search_macros.svh
// Assertion macros used by the support point search RTL.
`ifndef POLYGON_SUPPORT_POINT_SEARCH_MACROS_SVH
`define POLYGON_SUPPORT_POINT_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define PSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/pss_pkg.sv
// Types and constants of the support point search block.
package pss_pkg;

    localparam int IDX_BITS   = 8;
    localparam int CNT_BITS   = 9;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Word index of the vertex count register (paddr[2]).
    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

endpackage

### src/polygon_support_point_search.sv
// Polygon support point search: vertex store, scan sequencer and best-vertex tracking.
// A write request stores one vertex (an index at or above MAX_VERTICES is dropped) and
// gives no result. A query scans vertices 0 to vertex_count-1 (count 0 counts as 1,
// larger counts clip to MAX_VERTICES), reading one vertex a cycle from the vertex
// memory; the memory read, the multiplier register and the sum/compare stage follow
// the scan before the result reaches the output register. Ties go to the lower index.
// One item is worked at a time; a finished result waits in the output register while
// the next item is taken. Write vertex_count only while idle.
`include "polygon_support_point_search_macros.svh"

module polygon_support_point_search
    import pss_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // query / write channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_req_type,
    input  logic [IDX_BITS-1:0]          i_vert_index,
    input  logic signed [COORD_BITS-1:0] i_vert_x,
    input  logic signed [COORD_BITS-1:0] i_vert_y,
    input  logic signed [COORD_BITS-1:0] i_dir_x,
    input  logic signed [COORD_BITS-1:0] i_dir_y,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [IDX_BITS-1:0]          o_best_index,
    output logic signed [COORD_BITS-1:0] o_best_x,
    output logic signed [COORD_BITS-1:0] o_best_y,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    // One bit above the address so MAX_VERTICES itself is representable.
    localparam int SW  = ((AW + 1) > IDX_BITS) ? (AW + 1) : IDX_BITS;
    localparam int NW  = ((AW + 1) > CNT_BITS) ? (AW + 1) : CNT_BITS;
    localparam int DW  = 2 * COORD_BITS;
    localparam int SUMW = 2 * COORD_BITS + 1;

    t_state r_state, n_state;

    logic [CNT_BITS-1:0]          r_vertex_count;
    logic signed [COORD_BITS-1:0] r_dir_x, r_dir_y;
    logic [AW-1:0]                r_rd_idx;
    logic [AW-1:0]                r_last;

    logic          r_s1_vld, r_s1_last, r_s1_first;
    logic [AW-1:0] r_s1_idx;
    logic          r_s2_vld, r_s2_last, r_s2_first;
    logic [AW-1:0] r_s2_idx;

    logic signed [SUMW-1:0]       r_best_dot;
    logic [AW-1:0]                r_best_idx;
    logic signed [COORD_BITS-1:0] r_best_x, r_best_y;

    logic                         r_out_vld;
    logic [IDX_BITS-1:0]          r_out_idx;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;

    logic          in_accept, out_accept, cfg_write, out_free;
    logic          is_query, wr_en, wr_in_range;
    logic [SW-1:0] slot_ext;
    logic [NW-1:0] cnt_ext, n_clip;
    logic [AW-1:0] n_last;
    logic          scan_done;

    logic [DW-1:0]                rd_data;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic signed [DW-1:0]         s2_px, s2_py;
    logic signed [COORD_BITS-1:0] s2_x, s2_y;
    logic signed [SUMW-1:0]       dot_sum;
    logic                         take_best;

    // ---------------- handshakes ----------------
    assign o_stall    = (r_state != ST_IDLE);
    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_vld && !i_stall;
    assign out_free   = !r_out_vld || !i_stall;
    assign is_query   = (i_req_type == REQ_QUERY);

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_VERTEX_COUNT) ?
                       APB_DATA_W'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNT_BITS'(1);
        end else if (cfg_write && paddr[2] == REG_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[CNT_BITS-1:0];
        end
    end

    // ---------------- vertex writes ----------------
    assign slot_ext    = SW'(i_vert_index);
    assign wr_in_range = (slot_ext < SW'(MAX_VERTICES));
    assign wr_en       = in_accept && (i_req_type == REQ_WRITE) && wr_in_range;

    // Clip the count to 1..MAX_VERTICES and keep the last index to scan.
    always_comb begin
        cnt_ext = NW'(r_vertex_count);
        if (cnt_ext == '0) begin
            n_clip = NW'(1);
        end else if (cnt_ext > NW'(MAX_VERTICES)) begin
            n_clip = NW'(MAX_VERTICES);
        end else begin
            n_clip = cnt_ext;
        end
        n_last = AW'(n_clip - NW'(1));
    end

    pss_vmem #(
        .DEPTH  (MAX_VERTICES),
        .DATA_W (DW),
        .AW     (AW)
    ) u_vmem (
        .i_clk   (i_clk),
        .i_wen   (wr_en),
        .i_waddr (AW'(slot_ext)),
        .i_wdata ({i_vert_x, i_vert_y}),
        .i_ren   (r_state == ST_SCAN),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    assign rd_x = rd_data[DW-1:COORD_BITS];
    assign rd_y = rd_data[COORD_BITS-1:0];

    pss_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .i_clk   (i_clk),
        .i_dir_x (r_dir_x),
        .i_dir_y (r_dir_y),
        .i_vx    (rd_x),
        .i_vy    (rd_y),
        .o_px    (s2_px),
        .o_py    (s2_py),
        .o_vx    (s2_x),
        .o_vy    (s2_y)
    );

    // ---------------- sequencer ----------------
    assign scan_done = r_s2_vld && r_s2_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && is_query) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_accept && is_query) begin
            r_dir_x  <= i_dir_x;
            r_dir_y  <= i_dir_y;
            r_last   <= n_last;
            r_rd_idx <= '0;
        end else if (r_state == ST_SCAN) begin
            r_rd_idx <= r_rd_idx + AW'(1);
        end
    end

    // Tags that travel alongside the memory read and the multiplier stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == ST_SCAN);
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx   <= r_rd_idx;
        r_s1_last  <= (r_rd_idx == r_last);
        r_s1_first <= (r_rd_idx == '0);
        r_s2_idx   <= r_s1_idx;
        r_s2_last  <= r_s1_last;
        r_s2_first <= r_s1_first;
    end

    // ---------------- sum and compare ----------------
    assign dot_sum   = SUMW'(s2_px) + SUMW'(s2_py);
    // Strict compare: a later vertex wins only with a greater dot product.
    assign take_best = r_s2_vld && (r_s2_first || (dot_sum > r_best_dot));

    always_ff @(posedge i_clk) begin
        if (take_best) begin
            r_best_dot <= dot_sum;
            r_best_idx <= r_s2_idx;
            r_best_x   <= s2_x;
            r_best_y   <= s2_y;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_vld <= 1'b1;
        end else if (out_accept) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_idx <= IDX_BITS'(r_best_idx);
            r_out_x   <= r_best_x;
            r_out_y   <= r_best_y;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_best_index = r_out_idx;
    assign o_best_x     = r_out_x;
    assign o_best_y     = r_out_y;

    // ---------------- assertions ----------------
    `PSS_ASSERT_NEXT(a_query_starts_scan, i_clk, i_rst_n, in_accept && is_query,
        r_state == ST_SCAN && r_rd_idx == '0)
    `PSS_ASSERT_NEXT(a_last_ends_scan, i_clk, i_rst_n, scan_done, r_state == ST_DONE)
    `PSS_ASSERT_SAME(a_tags_in_scan, i_clk, i_rst_n, r_s1_vld || r_s2_vld,
        r_state == ST_SCAN || r_state == ST_DRAIN)
    `PSS_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, r_state == ST_DONE && out_free,
        o_valid && r_state == ST_IDLE)

endmodule

### src/pss_vmem.sv
// Vertex store: one write port, one read port with registered read data.
module pss_vmem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32,
    parameter int AW     = 8
) (
    input  logic              i_clk,
    input  logic              i_wen,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_ren,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/pss_dot.sv
// Dot product multiplier stage: registers both products and the vertex.
module pss_dot #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic signed [COORD_BITS-1:0]   i_dir_x,
    input  logic signed [COORD_BITS-1:0]   i_dir_y,
    input  logic signed [COORD_BITS-1:0]   i_vx,
    input  logic signed [COORD_BITS-1:0]   i_vy,
    output logic signed [2*COORD_BITS-1:0] o_px,
    output logic signed [2*COORD_BITS-1:0] o_py,
    output logic signed [COORD_BITS-1:0]   o_vx,
    output logic signed [COORD_BITS-1:0]   o_vy
);

    logic signed [2*COORD_BITS-1:0] r_px;
    logic signed [2*COORD_BITS-1:0] r_py;
    logic signed [COORD_BITS-1:0]   r_vx;
    logic signed [COORD_BITS-1:0]   r_vy;

    always_ff @(posedge i_clk) begin
        r_px <= i_dir_x * i_vx;
        r_py <= i_dir_y * i_vy;
        r_vx <= i_vx;
        r_vy <= i_vy;
    end

    assign o_px = r_px;
    assign o_py = r_py;
    assign o_vx = r_vx;
    assign o_vy = r_vy;

endmodule
